// ----- hw/rtl/battery_status_led_pattern_unit_defines.svh -----
// Assertion macros used by the checker in bslp_check.sv.
`ifndef BATTERY_STATUS_LED_PATTERN_UNIT_DEFINES_SVH
`define BATTERY_STATUS_LED_PATTERN_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BSLP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BSLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bslp_pkg.sv -----
// Shared types, codes and constants of the battery status LED pattern unit.
package bslp_pkg;

    localparam int TIME_BITS_DEF       = 32;
    localparam int SINE_PHASE_BITS_DEF = 8;

    localparam int PCT_W  = 7;
    localparam int CUR_W  = 16;
    localparam int NOW_W  = 32;
    localparam int LVL_W  = 8;
    localparam int PAT_W  = 3;
    localparam int MODE_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int DIV_W  = 11;

    // Pattern codes
    localparam logic [PAT_W-1:0] PAT_OFF  = 3'd0;
    localparam logic [PAT_W-1:0] PAT_SLOW = 3'd1;
    localparam logic [PAT_W-1:0] PAT_FAST = 3'd2;
    localparam logic [PAT_W-1:0] PAT_FULL = 3'd3;
    localparam logic [PAT_W-1:0] PAT_LOW  = 3'd4;
    localparam logic [PAT_W-1:0] PAT_CRIT = 3'd5;

    // Board modes
    localparam logic [MODE_W-1:0] MODE_GREEN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLUE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RGB   = 2'd2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL  = 2'd2;

    localparam logic [MODE_W-1:0]     MODE_RST = MODE_RGB;
    localparam logic [CFG_DATA_W-1:0] CRIT_RST = 7'd10;
    localparam logic [CFG_DATA_W-1:0] LOW_RST  = 7'd20;

    localparam logic [PCT_W-1:0]        FULL_PCT     = 7'd95;
    localparam logic signed [CUR_W-1:0] FAST_CUR_MA  = -16'sd500;

    // Periods in ms: pulse full period, blink half period
    localparam logic [DIV_W-1:0] PULSE_SLOW_MS      = 11'd2000;
    localparam logic [DIV_W-1:0] PULSE_FAST_MS      = 11'd1000;
    localparam logic [DIV_W-1:0] BLINK_LOW_MS       = 11'd1000;
    localparam logic [DIV_W-1:0] BLINK_CRIT_MS      = 11'd300;
    localparam logic [DIV_W-1:0] BLINK_CRIT_BLUE_MS = 11'd200;

    localparam logic [LVL_W-1:0] LVL_MAX    = 8'd255;
    localparam logic [LVL_W-1:0] LVL_THIRD  = 8'd85;
    localparam logic [LVL_W-1:0] LVL_GREEN_BLINK = 8'd100;

    // x / 3 == (x * 171) >> 9 for 8-bit x
    localparam logic [15:0] DIV3_RECIP = 16'd171;
    localparam int          DIV3_SHIFT = 9;

    localparam logic [7:0] SINE_QUARTER [0:64] = '{
        8'd0,   8'd6,   8'd13,  8'd19,  8'd25,  8'd31,  8'd37,  8'd44,
        8'd50,  8'd56,  8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,
        8'd98,  8'd103, 8'd109, 8'd115, 8'd120, 8'd126, 8'd131, 8'd136,
        8'd142, 8'd147, 8'd152, 8'd157, 8'd162, 8'd167, 8'd171, 8'd176,
        8'd180, 8'd185, 8'd189, 8'd193, 8'd197, 8'd201, 8'd205, 8'd208,
        8'd212, 8'd215, 8'd219, 8'd222, 8'd225, 8'd228, 8'd231, 8'd233,
        8'd236, 8'd238, 8'd240, 8'd242, 8'd244, 8'd246, 8'd247, 8'd249,
        8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255,
        8'd255
    };

    typedef struct packed {
        logic              load;
        logic [PAT_W-1:0]  pattern;
        logic [MODE_W-1:0] mode;
        logic [LVL_W-1:0]  bright_held;
        logic              green_held;
    } t_shape_ctl;

    typedef struct packed {
        logic [LVL_W-1:0] bright;
        logic             green;
    } t_shape_res;

endpackage

// ----- hw/rtl/bslp_ifs.sv -----
// Handshake channels: input update, result and config write.
interface bslp_in_if import bslp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [PCT_W-1:0]         battery_percent;
    logic                     on_charger;
    logic signed [CUR_W-1:0]  current_milliamps;
    logic [NOW_W-1:0]         now_ms;

    modport source (output valid, battery_percent, on_charger, current_milliamps, now_ms,
                    input ready);
    modport sink   (input valid, battery_percent, on_charger, current_milliamps, now_ms,
                    output ready);
endinterface

interface bslp_out_if import bslp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LVL_W-1:0]  led_brightness;
    logic              green_led_on;
    logic [PAT_W-1:0]  active_pattern;

    modport source (output valid, led_brightness, green_led_on, active_pattern, input ready);
    modport sink   (input valid, led_brightness, green_led_on, active_pattern, output ready);
endinterface

interface bslp_cfg_if import bslp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/battery_status_led_pattern_unit.sv -----
// Top level: classification, pattern timing state, sequencing and result register.
//
//  channel   dir  payload                                                   handshake
//  i_item    in   battery_percent, on_charger, current_milliamps, now_ms    valid/ready
//  o_result  out  led_brightness, green_led_on, active_pattern              valid/ready
//  i_cfg     in   index, data (board_mode, critical_level, low_level)       valid/ready
//
// After its accept an update runs through S_DIV, where the bit-serial divider yields one
// quotient bit per cycle, then S_LUT and S_FIN, where its result is registered; a new
// update is accepted only in S_IDLE, so updates do not overlap.
// The next update is accepted the cycle after the result is registered, even while it
// still waits on o_result.ready; a stalled result only holds the final step.
// Reset (synchronous, active low) clears the pattern state and loads config defaults.
// Config writes are always ready.
module battery_status_led_pattern_unit import bslp_pkg::*; #(
    parameter int TIME_BITS       = TIME_BITS_DEF,
    parameter int SINE_PHASE_BITS = SINE_PHASE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bslp_in_if.sink     i_item,
    bslp_out_if.source  o_result,
    bslp_cfg_if.sink    i_cfg
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_LUT  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [MODE_W-1:0]     r_mode;
    logic [CFG_DATA_W-1:0] r_crit;
    logic [CFG_DATA_W-1:0] r_low;

    logic [PAT_W-1:0]  r_pat;
    logic [NOW_W-1:0]  r_start;
    logic [LVL_W-1:0]  r_bright_held;
    logic              r_green_held;

    logic              r_ovalid;
    logic [LVL_W-1:0]  r_obright;
    logic              r_ogreen;
    logic [PAT_W-1:0]  r_opat;

    logic                     accept;
    logic                     finish;
    logic [PAT_W-1:0]         n_pat;
    logic                     changed;
    logic [TIME_BITS-1:0]     elapsed;
    logic [DIV_W-1:0]         divisor;
    logic                     div_done;
    logic [SINE_PHASE_BITS:0] quot;
    t_shape_ctl               shape_ctl;
    t_shape_res               shape_res;

    assign i_cfg.ready   = 1'b1;
    assign i_item.ready  = (r_state == S_IDLE);
    assign accept        = i_item.valid && (r_state == S_IDLE);
    assign finish        = (r_state == S_FIN) && (!r_ovalid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RST;
            r_crit <= CRIT_RST;
            r_low  <= LOW_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BOARD_MODE: r_mode <= i_cfg.data[MODE_W-1:0];
                CFG_CRIT_LEVEL: r_crit <= i_cfg.data;
                CFG_LOW_LEVEL:  r_low  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (i_item.battery_percent < r_crit) begin
            n_pat = PAT_CRIT;
        end else if (i_item.battery_percent < r_low) begin
            n_pat = PAT_LOW;
        end else if (i_item.battery_percent >= FULL_PCT) begin
            n_pat = PAT_FULL;
        end else if (i_item.on_charger) begin
            n_pat = (i_item.current_milliamps < FAST_CUR_MA) ? PAT_FAST : PAT_SLOW;
        end else begin
            n_pat = PAT_OFF;
        end
        changed = (n_pat != r_pat);
        elapsed = changed ? '0 : (TIME_BITS'(i_item.now_ms) - TIME_BITS'(r_start));
        case (n_pat)
            PAT_FAST: divisor = PULSE_FAST_MS;
            PAT_LOW:  divisor = BLINK_LOW_MS;
            PAT_CRIT: divisor = (r_mode == MODE_BLUE) ? BLINK_CRIT_BLUE_MS : BLINK_CRIT_MS;
            default:  divisor = PULSE_SLOW_MS;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_LUT;
            S_LUT:   n_state = S_FIN;
            S_FIN:   if (finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pat         <= PAT_OFF;
            r_start       <= '0;
            r_bright_held <= '0;
            r_green_held  <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && changed) begin
                r_pat   <= n_pat;
                r_start <= i_item.now_ms;
            end
            if (finish) begin
                r_bright_held <= shape_res.bright;
                r_green_held  <= shape_res.green;
                r_ovalid      <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_obright <= shape_res.bright;
            r_ogreen  <= shape_res.green;
            r_opat    <= r_pat;
        end
    end

    assign shape_ctl.load        = div_done;
    assign shape_ctl.pattern     = r_pat;
    assign shape_ctl.mode        = r_mode;
    assign shape_ctl.bright_held = r_bright_held;
    assign shape_ctl.green_held  = r_green_held;

    bslp_sdiv #(
        .TIME_BITS       (TIME_BITS),
        .SINE_PHASE_BITS (SINE_PHASE_BITS)
    ) u_sdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (elapsed),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    bslp_shape #(
        .SINE_PHASE_BITS (SINE_PHASE_BITS)
    ) u_shape (
        .i_clk  (i_clk),
        .i_quot (quot),
        .i_ctl  (shape_ctl),
        .o_res  (shape_res)
    );

    assign o_result.valid          = r_ovalid;
    assign o_result.led_brightness = r_obright;
    assign o_result.green_led_on   = r_ogreen;
    assign o_result.active_pattern = r_opat;
endmodule

// ----- hw/rtl/bslp_sdiv.sv -----
// Bit-serial restoring divider: low quotient bits of (dividend << SPB) / divisor.
module bslp_sdiv import bslp_pkg::*; #(
    parameter int TIME_BITS       = TIME_BITS_DEF,
    parameter int SINE_PHASE_BITS = SINE_PHASE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [TIME_BITS-1:0]     i_dividend,
    input  logic [DIV_W-1:0]         i_divisor,
    output logic                     o_done,
    output logic [SINE_PHASE_BITS:0] o_quot
);
    localparam int STEPS = TIME_BITS + SINE_PHASE_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic [TIME_BITS-1:0]     r_dvd;
    logic [DIV_W-1:0]         r_dsr;
    logic [DIV_W-1:0]         r_rem;
    logic [SINE_PHASE_BITS:0] r_quo;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_done;

    logic [DIV_W:0]   cand;
    logic             ge;
    logic [DIV_W:0]   diff;

    always_comb begin
        cand = {r_rem, r_dvd[TIME_BITS-1]};
        ge   = cand >= {1'b0, r_dsr};
        diff = cand - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // zeros shift in behind the dividend, giving the fractional phase bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_BITS-2:0], 1'b0};
            r_rem <= ge ? diff[DIV_W-1:0] : cand[DIV_W-1:0];
            r_quo <= {r_quo[SINE_PHASE_BITS-1:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ----- hw/rtl/bslp_shape.sv -----
// Sine lookup, pulse level and per-mode brightness / green selection.
module bslp_shape import bslp_pkg::*; #(
    parameter int SINE_PHASE_BITS = SINE_PHASE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic [SINE_PHASE_BITS:0] i_quot,
    input  t_shape_ctl               i_ctl,
    output t_shape_res               o_res
);
    localparam int PW   = SINE_PHASE_BITS + 8;
    localparam int DOWN = (SINE_PHASE_BITS > 8) ? SINE_PHASE_BITS - 8 : 0;
    localparam int UP   = (SINE_PHASE_BITS < 8) ? 8 - SINE_PHASE_BITS : 0;

    logic [PW-1:0] ph_w;
    logic [7:0]    p8;
    logic [1:0]    quad;
    logic [5:0]    idx;
    logic [6:0]    tidx;
    logic [7:0]    mag;
    logic [8:0]    inten_w;
    logic [15:0]   lvl_w;
    logic [15:0]   third_w;
    logic [7:0]    lvl_third;
    logic          div3;

    logic [LVL_W-1:0] r_lvl;
    logic             r_gs;
    logic             r_late;

    always_comb begin
        ph_w = PW'(i_quot[SINE_PHASE_BITS-1:0]);
        p8   = 8'((ph_w >> DOWN) << UP);
        quad = p8[7:6];
        idx  = p8[5:0];
        tidx = quad[0] ? (7'd64 - {1'b0, idx}) : {1'b0, idx};
        mag  = SINE_QUARTER[tidx];
        // negative half-wave: (255 - mag) >> 1, else (255 + mag) >> 1
        inten_w = quad[1] ? ((9'd255 - {1'b0, mag}) >> 1) : ((9'd255 + {1'b0, mag}) >> 1);
        lvl_w   = (16'(inten_w[7:0]) * 16'(LVL_MAX)) >> 8;
    end

    // r_late: elapsed falls in the second half of a blink cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_lvl  <= lvl_w[LVL_W-1:0];
            r_gs   <= !quad[1] && (mag != 8'd0);
            r_late <= i_quot[SINE_PHASE_BITS];
        end
    end

    always_comb begin
        third_w   = (16'(r_lvl) * DIV3_RECIP) >> DIV3_SHIFT;
        lvl_third = third_w[7:0];
        div3      = (i_ctl.mode != MODE_BLUE);
        o_res.bright = i_ctl.bright_held;
        o_res.green  = i_ctl.green_held;
        if (i_ctl.mode == MODE_GREEN) begin
            case (i_ctl.pattern)
                PAT_OFF: begin
                    o_res.bright = '0;
                    o_res.green  = 1'b0;
                end
                PAT_SLOW, PAT_FAST: begin
                    o_res.green  = r_gs;
                    o_res.bright = r_gs ? i_ctl.bright_held : '0;
                end
                PAT_FULL: begin
                    o_res.green = 1'b1;
                end
                default: begin
                    o_res.bright = r_late ? '0 : LVL_GREEN_BLINK;
                end
            endcase
        end else begin
            case (i_ctl.pattern)
                PAT_OFF: begin
                    o_res.bright = '0;
                end
                PAT_SLOW, PAT_FAST: begin
                    o_res.bright = div3 ? lvl_third : r_lvl;
                end
                PAT_FULL: begin
                    o_res.bright = div3 ? LVL_THIRD : LVL_MAX;
                end
                default: begin
                    o_res.bright = r_late ? '0 : (div3 ? LVL_THIRD : LVL_MAX);
                end
            endcase
        end
    end
endmodule

// ----- hw/rtl/bslp_check.sv -----
// Port-level checker for the battery status LED pattern unit, with its bind.
`include "battery_status_led_pattern_unit_defines.svh"

module bslp_check import bslp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [LVL_W-1:0] i_out_bright,
    input logic [PAT_W-1:0] i_out_pat
);
    `BSLP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_bright) && $stable(i_out_pat), "result beat dropped or changed while stalled")
    `BSLP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "new beat taken while an update is in progress")
    `BSLP_ASSERT_SAME(a_off_dark, i_clk, i_rst_n, i_out_valid && (i_out_pat == PAT_OFF), i_out_bright == '0, "off pattern with LED lit")
    `BSLP_ASSERT_SAME(a_blink_levels, i_clk, i_rst_n, i_out_valid && ((i_out_pat == PAT_LOW) || (i_out_pat == PAT_CRIT)), (i_out_bright == '0) || (i_out_bright == LVL_THIRD) || (i_out_bright == LVL_GREEN_BLINK) || (i_out_bright == LVL_MAX), "blink level out of set")
endmodule

bind battery_status_led_pattern_unit bslp_check u_bslp_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_bright (o_result.led_brightness),
    .i_out_pat    (o_result.active_pattern)
);
